>>> rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selection core.
// Holds field widths, opcode and status codes, controller states and the
// command and status words passed between the controller and the datapath.
package rws_pkg;

  // Fixed field widths of the block's ports and of its internal sums.
  localparam int POP_SIZE_W = 9;
  localparam int FIT_W      = 24;
  localparam int RAND_W     = 32;
  localparam int SUM_W      = 32;
  localparam int INDEX_W    = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_POP      = 256;
  localparam int DEF_FITNESS_BITS = 24;

  // Reset value of the population size register.
  localparam logic [POP_SIZE_W-1:0] POP_SIZE_RESET = 9'd256;

  // Input word opcodes.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SELECT = 1'b1
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_READY  = 2'd1,
    STAT_ZERO_TOTAL = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_CMP  = 2'd2
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // append one fitness word
    logic    sel_start;  // register the target and open the search window
    logic    rd_issue;   // read the prefix sum at the window midpoint
    logic    step;       // narrow the window using the read data
    logic    emit;       // drive one result word
    status_t code;       // status of the emitted word
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic table_ready;   // table complete and non-empty
    logic total_zero;    // running total is zero
    logic search_done;   // search window has closed
  } dp_stat_t;

endpackage : rws_pkg

>>> rtl/roulette_wheel_select_core.sv
// Top level of the roulette wheel selection core.
// Joins the controller (rws_ctrl) and the datapath (rws_dpath); uses rws_pkg.
//
// A word is taken when start is high and busy is low. A load word (opcode 0)
// appends one fitness value to the prefix-sum table, gives no result, and
// leaves busy low. A select word (opcode 1) gives one result, strobed by
// out_valid for one cycle; the receiver cannot stall it. An error select
// (table not full, or zero total) answers on the next cycle without raising
// busy. A good select registers the scaled target at acceptance, then runs a
// binary search in which each halving is one prefix-sum memory read followed
// by one compare. Busy drops with the strobe, so the next word can be taken
// while the strobe is high. Each halving waits on the single registered read
// port of the prefix-sum memory. No clearing pass is needed after reset.
module roulette_wheel_select_core #(
  parameter int MAX_POP      = rws_pkg::DEF_MAX_POP,
  parameter int FITNESS_BITS = rws_pkg::DEF_FITNESS_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rws_pkg::POP_SIZE_W-1:0] cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [rws_pkg::FIT_W-1:0]      in_fitness_value,
  input  logic [rws_pkg::RAND_W-1:0]     in_random_fraction,
  output logic                           out_valid,
  output logic [rws_pkg::INDEX_W-1:0]    out_chosen_index,
  output logic [1:0]                     out_status
);
  import rws_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Table, arithmetic and result registers.
  rws_dpath #(
    .MAX_POP      (MAX_POP),
    .FITNESS_BITS (FITNESS_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_fitness_value   (in_fitness_value),
    .in_random_fraction (in_random_fraction),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid          (out_valid),
    .out_chosen_index   (out_chosen_index),
    .out_status         (out_status)
  );

endmodule : roulette_wheel_select_core

>>> rtl/rws_ctrl.sv
// Controller state machine for the roulette wheel selection core.
// Decodes accepted words and sequences the binary search; depends on rws_pkg.
module rws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_opcode,
  input  rws_pkg::dp_stat_t stat_i,
  output rws_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);
  import rws_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    cmd_o.code = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (!stat_i.table_ready) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = STAT_NOT_READY;
          end else if (stat_i.total_zero) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = STAT_ZERO_TOTAL;
          end else begin
            cmd_o.sel_start = 1'b1;
            state_nxt       = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (stat_i.search_done) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = STAT_OK;
          state_nxt  = ST_IDLE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_nxt      = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.step = 1'b1;
        state_nxt  = ST_READ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // A compare step always follows a read, and the read state always follows it.
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> $past(state_r) == ST_READ)
    else $error("compare step without a preceding read");

  // Loads and search steps never overlap.
  a_load_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |-> !(cmd_o.step || cmd_o.rd_issue || cmd_o.emit))
    else $error("load issued during a search");

  // A search starts only on a ready table with a nonzero total.
  a_sel_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.sel_start |-> stat_i.table_ready && !stat_i.total_zero)
    else $error("search started on a table that cannot be selected");

endmodule : rws_ctrl

>>> rtl/rws_dpath.sv
// Datapath for the roulette wheel selection core: prefix-sum memory, running
// total, search window and result registers; depends on rws_pkg.
module rws_dpath #(
  parameter int MAX_POP      = rws_pkg::DEF_MAX_POP,
  parameter int FITNESS_BITS = rws_pkg::DEF_FITNESS_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rws_pkg::POP_SIZE_W-1:0]      cfg_wdata,
  input  logic [rws_pkg::FIT_W-1:0]           in_fitness_value,
  input  logic [rws_pkg::RAND_W-1:0]          in_random_fraction,
  input  rws_pkg::dp_cmd_t                    cmd_i,
  output rws_pkg::dp_stat_t                   stat_o,
  output logic                                out_valid,
  output logic [rws_pkg::INDEX_W-1:0]         out_chosen_index,
  output logic [1:0]                          out_status
);
  import rws_pkg::*;

  localparam int IDX_W = $clog2(MAX_POP);
  localparam int PTR_W = $clog2(MAX_POP + 1);
  localparam int CMP_W = (PTR_W > POP_SIZE_W) ? PTR_W : POP_SIZE_W;
  localparam logic [SUM_W-1:0] FIT_MASK = SUM_W'((64'd1 << FITNESS_BITS) - 64'd1);
  localparam logic [CMP_W-1:0] MAX_POP_C = CMP_W'(MAX_POP);
  localparam logic [PTR_W-1:0] MAX_POP_P = PTR_W'(MAX_POP);

  logic [SUM_W-1:0]      mem [MAX_POP];
  logic [POP_SIZE_W-1:0] pop_size_r;
  logic [SUM_W-1:0]      total_r;
  logic [PTR_W-1:0]      wp_r;
  logic                  full_r;
  logic [SUM_W-1:0]      target_r;
  logic [IDX_W-1:0]      lo_r;
  logic [IDX_W-1:0]      hi_r;
  logic [SUM_W-1:0]      rd_data_r;
  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_index_r;
  status_t               out_status_r;

  logic [CMP_W-1:0]      eff_pop;
  logic [SUM_W-1:0]      fit;
  logic [SUM_W-1:0]      base_total;
  logic [PTR_W-1:0]      base_wp;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_sat;
  logic                  wr_en;
  logic [PTR_W-1:0]      wp_nxt;
  logic [2*SUM_W-1:0]    product;
  logic [IDX_W-1:0]      mid;

  // Effective population size: zero reads as one, large values as the table depth.
  always_comb begin
    eff_pop = CMP_W'(pop_size_r);
    if (eff_pop == '0) begin
      eff_pop = CMP_W'(1);
    end else if (eff_pop > MAX_POP_C) begin
      eff_pop = MAX_POP_C;
    end
  end

  // Load arithmetic; a load into a full table starts a new generation.
  always_comb begin
    fit        = SUM_W'(in_fitness_value) & FIT_MASK;
    base_total = full_r ? '0 : total_r;
    base_wp    = full_r ? '0 : wp_r;
    sum_wide   = {1'b0, base_total} + {1'b0, fit};
    sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    wr_en      = (base_wp < MAX_POP_P);
    wp_nxt     = wr_en ? base_wp + PTR_W'(1) : base_wp;
  end

  // Target is the fraction scaled by the total, upper half of the product.
  assign product = (2*SUM_W)'(in_random_fraction) * (2*SUM_W)'(total_r);
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r <= POP_SIZE_RESET;
    end else if (cfg_we) begin
      pop_size_r <= cfg_wdata;
    end
  end

  // Table control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
    end else if (cmd_i.load) begin
      total_r <= sum_sat;
      wp_r    <= wp_nxt;
      full_r  <= (CMP_W'(wp_nxt) >= eff_pop);
    end
  end

  // Prefix-sum memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd_i.load && wr_en) begin
      mem[base_wp[IDX_W-1:0]] <= sum_sat;
    end
    if (cmd_i.rd_issue) begin
      rd_data_r <= mem[mid];
    end
  end

  // Search window: lower bound rises past sums not above the target, upper bound drops to a sum above it.
  always_ff @(posedge clk) begin
    if (cmd_i.sel_start) begin
      target_r <= product[2*SUM_W-1:SUM_W];
      lo_r     <= '0;
      hi_r     <= IDX_W'(wp_r - PTR_W'(1));
    end else if (cmd_i.step) begin
      if (rd_data_r > target_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + IDX_W'(1);
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_status_r <= cmd_i.code;
      out_index_r  <= (cmd_i.code == STAT_OK) ? INDEX_W'(lo_r) : '0;
    end
  end

  assign stat_o.table_ready = full_r && (wp_r != '0);
  assign stat_o.total_zero  = (total_r == '0);
  assign stat_o.search_done = (lo_r >= hi_r);

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_index_r;
  assign out_status       = out_status_r;

  // A search step only happens while the window is still open.
  a_step_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step |-> lo_r < hi_r)
    else $error("search step on a closed window");

  // Error results always carry index zero.
  a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_OK) |-> out_index_r == '0)
    else $error("error result with nonzero index");

  // A full table always holds at least one entry.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> wp_r != '0)
    else $error("full table with no entries");

  // The write pointer never passes the table depth.
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= MAX_POP_P)
    else $error("write pointer beyond table depth");

endmodule : rws_dpath
